// ===== design/weighted_histogram_accumulator_assert.svh =====
// Assertion macros shared by the weighted histogram accumulator.
// Stand-alone header: no package or module dependencies.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define WHA_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define WHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WHA_ASSERT_RST(lbl, clk, rst, prop, msg)
`define WHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/whist_pkg.sv =====
// Shared constants, types and helpers for the weighted histogram accumulator.
// No dependencies; imported by every module of the block except whist_ram.
package whist_pkg;

  localparam int BIN_DEPTH    = 4096;
  localparam int MAX_CHANNELS = 3;
  localparam int COUNT_WIDTH  = 32;

  localparam int BIN_AW       = $clog2(BIN_DEPTH);
  localparam int VALUE_WIDTH  = 8;
  localparam int WEIGHT_WIDTH = 8;
  localparam int OFFSET_WIDTH = 12;
  localparam int ENTRY_WIDTH  = OFFSET_WIDTH + 1;
  localparam int LUT_SPAN     = 256;
  localparam int SUM_WIDTH    = OFFSET_WIDTH + 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 2;

  typedef logic [BIN_AW-1:0]      bin_addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SUM_WIDTH-1:0]   bin_sum_t;
  typedef logic [MAX_CHANNELS-1:0][VALUE_WIDTH-1:0] chan_vec_t;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  localparam cfg_index_t CFG_CHANNEL_COUNT = 1'b0;
  localparam cfg_index_t CFG_USE_WEIGHTS   = 1'b1;

  // Input beat layout, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]              pad;
    logic [11:0]             read_address;
    logic                    entry_valid;
    logic [OFFSET_WIDTH-1:0] entry_offset;
    logic [7:0]              entry_value;
    logic [1:0]              entry_channel;
    logic                    pixel_enabled;
    logic [WEIGHT_WIDTH-1:0] pixel_weight;
    logic [VALUE_WIDTH-1:0]  chan_c_value;
    logic [VALUE_WIDTH-1:0]  chan_b_value;
    logic [VALUE_WIDTH-1:0]  chan_a_value;
  } in_beat_t;

  typedef struct packed {
    logic                    valid;
    logic [OFFSET_WIDTH-1:0] offset;
  } lut_entry_t;

  typedef struct packed {
    logic       en;
    logic [1:0] chan;
    logic [7:0] value;
    lut_entry_t entry;
  } lut_wr_t;

  typedef struct packed {
    logic                    rd_en;
    bin_addr_t               rd_addr;
    logic                    upd_en;
    bin_addr_t               upd_addr;
    logic [WEIGHT_WIDTH-1:0] amount;
    logic                    clr_en;
    bin_addr_t               clr_addr;
  } bin_ctrl_t;

  // Zero counts as one channel; anything above the build limit saturates.
  function automatic logic [1:0] eff_channels(input logic [1:0] cc);
    logic [1:0] r;
    r = cc;
    if (cc == 2'd0) r = 2'd1;
    if (int'(cc) > MAX_CHANNELS) r = 2'(MAX_CHANNELS);
    return r;
  endfunction

endpackage

// ===== design/weighted_histogram_accumulator.sv =====
// Weighted histogram accumulator: top level with the sequencing state machine.
// Depends on whist_pkg, whist_lut, whist_bins and the assertion macro header.
//
// The block keeps a histogram of BIN_DEPTH saturating counters in one
// synchronous RAM and three 256-entry offset tables, one per pixel channel.
// Each input beat carries an operation in s_tuser. An accumulate beat looks
// up each used channel in its table, adds the offsets into a bin address,
// reads that bin, and writes back the count plus the pixel weight (or plus
// one when use_weights is 0), saturating at the counter maximum; a masked
// pixel, an invalid table entry or an address past the last bin leaves the
// store untouched. Items are handled one at a time: an accumulate that
// updates a bin passes through accept, table read and bin read-modify-write;
// a masked pixel ends at accept and a pixel dropped at the lookup after the
// table read. A table load is written in the accept cycle, a read waits for
// any previous result to leave the output register, and a clear starts a
// sweep over all BIN_DEPTH bins that writes one bin per cycle through the
// bin RAM's single write port. After reset the same sweep runs before the
// first beat is taken; configuration writes are taken at all times. Reading
// a table entry that was never loaded gives an undefined result, so software
// loads every entry it will use. A read result waits in the output register
// without holding up the input side.
`include "weighted_histogram_accumulator_assert.svh"
module weighted_histogram_accumulator import whist_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // Input stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // From bit 0: chan_a_value[8], chan_b_value[8], chan_c_value[8],
  // pixel_weight[8], pixel_enabled[1], entry_channel[2], entry_value[8],
  // entry_offset[12], entry_valid[1], read_address[12], zero pad[4].
  input  logic [71:0]                s_tdata,
  // From bit 0: op[2].
  input  logic [1:0]                 s_tuser,
  // Result stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // From bit 0: bin_count[32].
  output logic [31:0]                m_tdata,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_READ
  } state_t;

  localparam bin_addr_t BIN_LAST = bin_addr_t'(BIN_DEPTH - 1);

  state_t                  state;
  bin_addr_t               clear_pointer;
  logic [1:0]              channel_count;
  logic                    use_weights;
  logic [WEIGHT_WIDTH-1:0] amount;
  bin_addr_t               upd_addr;
  logic                    read_zero;

  in_beat_t   beat;
  op_t        op;
  logic       accept;
  logic       out_free;
  logic [2:0][VALUE_WIDTH-1:0] pixel_all;
  chan_vec_t  pixel_vals;
  lut_wr_t    lut_wr;
  bin_sum_t   lut_sum;
  logic       lut_hit;
  logic       sum_ok;
  logic       read_ok;
  bin_ctrl_t  bin_ctrl;
  count_t     bin_rd_data;

  assign beat      = in_beat_t'(s_tdata);
  assign op        = op_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  // The output register can take a new result when empty or being drained.
  assign out_free  = !m_tvalid || m_tready;

  assign pixel_all  = {beat.chan_c_value, beat.chan_b_value, beat.chan_a_value};
  assign pixel_vals = pixel_all[MAX_CHANNELS-1:0];

  // Table loads go straight into the offset RAM in the accept cycle.
  always_comb begin
    lut_wr.en           = accept && (op == OP_LOAD);
    lut_wr.chan         = beat.entry_channel;
    lut_wr.value        = beat.entry_value;
    lut_wr.entry.valid  = beat.entry_valid;
    lut_wr.entry.offset = beat.entry_offset;
  end

  whist_lut u_lut (
    .clk      (clk),
    .wr       (lut_wr),
    .rd_en    (accept && (op == OP_ACCUM)),
    .rd_values(pixel_vals),
    .chans    (eff_channels(channel_count)),
    .sum      (lut_sum),
    .hit      (lut_hit)
  );

  assign sum_ok  = lut_hit && (32'(lut_sum) < 32'(BIN_DEPTH));
  assign read_ok = 32'(beat.read_address) < 32'(BIN_DEPTH);

  // The bin RAM is read either for a read beat or for the accumulate
  // that just finished its table lookup; the two never meet.
  always_comb begin
    bin_ctrl.rd_en    = (accept && (op == OP_READ) && read_ok)
                     || ((state == ST_LOOKUP) && sum_ok);
    bin_ctrl.rd_addr  = (state == ST_LOOKUP) ? bin_addr_t'(lut_sum)
                                             : bin_addr_t'(beat.read_address);
    bin_ctrl.upd_en   = (state == ST_UPDATE);
    bin_ctrl.upd_addr = upd_addr;
    bin_ctrl.amount   = amount;
    bin_ctrl.clr_en   = (state == ST_CLEAR);
    bin_ctrl.clr_addr = clear_pointer;
  end

  whist_bins u_bins (
    .clk    (clk),
    .ctrl   (bin_ctrl),
    .rd_data(bin_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_pointer <= '0;
      m_tvalid      <= 1'b0;
      channel_count <= 2'd1;
      use_weights   <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
          CFG_USE_WEIGHTS:   use_weights   <= cfg_data[0];
          default: ;
        endcase
      end

      // In the read state the output register is refilled below instead.
      if (m_tvalid && m_tready && (state != ST_READ)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (clear_pointer == BIN_LAST) begin
            clear_pointer <= '0;
            state         <= ST_IDLE;
          end else begin
            clear_pointer <= clear_pointer + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_ACCUM: begin
                amount <= use_weights ? beat.pixel_weight : WEIGHT_WIDTH'(1);
                state  <= beat.pixel_enabled ? ST_LOOKUP : ST_IDLE;
              end
              OP_LOAD:  state <= ST_IDLE;
              OP_CLEAR: state <= ST_CLEAR;
              OP_READ: begin
                read_zero <= !read_ok;
                state     <= ST_READ;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LOOKUP: begin
          if (sum_ok) begin
            upd_addr <= bin_addr_t'(lut_sum);
            state    <= ST_UPDATE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_UPDATE: state <= ST_IDLE;
        ST_READ: begin
          // The RAM read data holds while the output register is still full.
          if (out_free) begin
            m_tdata  <= read_zero ? 32'd0 : 32'(bin_rd_data);
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `WHA_ASSERT_RST(a_idle_ptr_zero, clk, rst, (state == ST_IDLE) |-> (clear_pointer == '0), "clear pointer not home while idle")
  `WHA_ASSERT_RST(a_accum_lookup, clk, rst, accept && (op == OP_ACCUM) && beat.pixel_enabled |=> (state == ST_LOOKUP), "enabled pixel skipped lookup")
  `WHA_ASSERT_RST(a_update_addr, clk, rst, (state == ST_UPDATE) |-> $past(bin_ctrl.rd_en) && (bin_ctrl.upd_addr == $past(bin_ctrl.rd_addr)), "bin write-back address differs from the read")
  `WHA_ASSERT_RST(a_read_lands, clk, rst, (state == ST_READ) && out_free |=> m_tvalid, "read result not registered")

endmodule

// ===== design/whist_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module whist_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/whist_lut.sv =====
// Per-channel offset tables and the bin address adder.
// Depends on whist_pkg and whist_ram.
module whist_lut import whist_pkg::*; (
  input  logic      clk,
  input  lut_wr_t   wr,
  input  logic      rd_en,
  input  chan_vec_t rd_values,
  input  logic [1:0] chans,
  output bin_sum_t  sum,
  output logic      hit
);

  logic [ENTRY_WIDTH-1:0] rd_raw [MAX_CHANNELS];
  lut_entry_t             rd_entry [MAX_CHANNELS];

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    whist_ram #(
      .DEPTH(LUT_SPAN),
      .WIDTH(ENTRY_WIDTH)
    ) u_ram (
      .clk  (clk),
      .we   (wr.en && (wr.chan == 2'(g))),
      .waddr(wr.value),
      .wdata(wr.entry),
      .re   (rd_en),
      .raddr(rd_values[g]),
      .rdata(rd_raw[g])
    );
    assign rd_entry[g] = lut_entry_t'(rd_raw[g]);
  end

  // Only the channels in use take part; any invalid one drops the pixel.
  always_comb begin
    sum = '0;
    hit = 1'b1;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (i < int'(chans)) begin
        if (!rd_entry[i].valid) hit = 1'b0;
        sum = sum + SUM_WIDTH'(rd_entry[i].offset);
      end
    end
  end

endmodule

// ===== design/whist_bins.sv =====
// Bin counter store with saturating read-modify-write and a zeroing port.
// Depends on whist_pkg and whist_ram.
module whist_bins import whist_pkg::*; (
  input  logic      clk,
  input  bin_ctrl_t ctrl,
  output count_t    rd_data
);

  logic [COUNT_WIDTH:0] grown;
  count_t               upd_value;
  logic                 we;
  bin_addr_t            waddr;
  count_t               wdata;

  // The counter was read in the previous cycle at the same address.
  always_comb begin
    grown = {1'b0, rd_data} + {{(COUNT_WIDTH + 1 - WEIGHT_WIDTH){1'b0}}, ctrl.amount};
    upd_value = grown[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : grown[COUNT_WIDTH-1:0];
    we    = ctrl.clr_en || ctrl.upd_en;
    waddr = ctrl.clr_en ? ctrl.clr_addr : ctrl.upd_addr;
    wdata = ctrl.clr_en ? '0 : upd_value;
  end

  whist_ram #(
    .DEPTH(BIN_DEPTH),
    .WIDTH(COUNT_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctrl.rd_en),
    .raddr(ctrl.rd_addr),
    .rdata(rd_data)
  );

endmodule

// ===== dv/whist_checker.sv =====
// Checker for the weighted histogram accumulator: predicts read results and compares them.
// Depends on whist_pkg; watches the input, result and configuration channels.
`timescale 1ns / 1ps
module whist_checker import whist_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [71:0]                s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [31:0]                m_tdata,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         failures,
  output int                         pending
);

  localparam count_t COUNT_FULL = '1;

  logic [ENTRY_WIDTH-1:0] offset_lut [MAX_CHANNELS*LUT_SPAN];
  count_t                 bin_counts [BIN_DEPTH];
  logic [1:0]             chan_setting;
  logic                   weight_setting;
  count_t                 expected_counts [$];
  count_t                 want;

  // Mirrors one accepted beat on the histogram; a read queues the count it must return.
  task automatic apply_beat(input op_t op, input in_beat_t b);
    logic [7:0]             vals [3];
    logic [ENTRY_WIDTH-1:0] e;
    int unsigned            nch;
    int unsigned            sum;
    bit                     drop;
    count_t                 add;
    count_t                 cur;
    vals[0] = b.chan_a_value;
    vals[1] = b.chan_b_value;
    vals[2] = b.chan_c_value;
    case (op)
      OP_ACCUM: begin
        if (b.pixel_enabled) begin
          nch = (chan_setting == 2'd0) ? 1 : chan_setting;
          if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
          sum = 0;
          drop = 1'b0;
          for (int c = 0; c < nch; c++) begin
            e = offset_lut[c*LUT_SPAN + vals[c]];
            if (!e[OFFSET_WIDTH]) drop = 1'b1;
            sum += e[OFFSET_WIDTH-1:0];
          end
          if (!drop && sum < BIN_DEPTH) begin
            add = weight_setting ? count_t'(b.pixel_weight) : count_t'(1);
            cur = bin_counts[sum];
            if (add > COUNT_FULL - cur) cur = COUNT_FULL;
            else cur = cur + add;
            bin_counts[sum] = cur;
          end
        end
      end
      OP_LOAD: begin
        if (b.entry_channel < MAX_CHANNELS)
          offset_lut[b.entry_channel*LUT_SPAN + b.entry_value] = {b.entry_valid, b.entry_offset};
      end
      OP_CLEAR: begin
        foreach (bin_counts[i]) bin_counts[i] = '0;
      end
      default: begin
        expected_counts.push_back(bin_counts[b.read_address]);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
      foreach (offset_lut[i]) offset_lut[i] = '0;
      chan_setting = 2'd1;
      weight_setting = 1'b1;
      expected_counts.delete();
    end else begin
      // Results leave first: a result can never belong to a beat taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected bin_count beat, expected none, actual %0d", $time, m_tdata);
          failures++;
        end else begin
          want = expected_counts.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: bin_count mismatch, expected %0d, actual %0d", $time, want, m_tdata);
            failures++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNEL_COUNT: chan_setting = cfg_data;
          CFG_USE_WEIGHTS:   weight_setting = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) apply_beat(op_t'(s_tuser), in_beat_t'(s_tdata));
    end
    pending = expected_counts.size();
  end

endmodule

// ===== dv/weighted_histogram_accumulator_tb.sv =====
// Testbench top for the weighted histogram accumulator: clock, reset, stimulus and verdict.
// Depends on whist_pkg, the block itself and the whist_checker module in this folder.
`timescale 1ns / 1ps
module weighted_histogram_accumulator_tb import whist_pkg::*;;

  // Each clear sweeps the whole bin store; the drain pause has to cover one sweep.
  localparam int SETTLE_CYCLES   = BIN_DEPTH + 64;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int MAX_CLEARS      = 6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [71:0]                s_tdata;
  logic [1:0]                 s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [31:0]                m_tdata;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  int failures;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int clears_left = MAX_CLEARS;

  // Table entries written so far, per channel. Pixels only ever use these values, so
  // the block never looks up an entry that holds no defined content.
  bit loaded [3][256];
  int loaded_count [3];

  weighted_histogram_accumulator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  whist_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver decides its stall for the next edge at every falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Uniform binning: channel a gives 16 steps, b four steps of 16, c two steps of 64,
  // so the sum stays within the first 128 bins and reads find real counts.
  function automatic logic [11:0] uniform_offset(input int ch, input logic [7:0] v);
    case (ch)
      0:       return 12'(v >> 4);
      1:       return 12'((v >> 6) * 16);
      default: return 12'((v >> 7) * 64);
    endcase
  endfunction

  function automatic logic [7:0] pick_value(input int ch);
    logic [7:0] v;
    if (loaded_count[ch] == 0) return 8'd0;
    do v = 8'($urandom_range(0, 255)); while (!loaded[ch][v]);
    return v;
  endfunction

  // Every field random; channel values only from loaded table entries.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.pad           = '0;
    b.read_address  = 12'($urandom_range(0, 4095));
    b.entry_valid   = 1'($urandom_range(0, 1));
    b.entry_offset  = 12'($urandom_range(0, 4095));
    b.entry_value   = 8'($urandom_range(0, 255));
    b.entry_channel = 2'($urandom_range(0, 3));
    b.pixel_enabled = 1'($urandom_range(0, 1));
    b.pixel_weight  = 8'($urandom_range(0, 255));
    b.chan_c_value  = pick_value(2);
    b.chan_b_value  = pick_value(1);
    b.chan_a_value  = pick_value(0);
    return b;
  endfunction

  // Called and left at a falling edge; valid stays up after the beat so that the
  // next call either drops it for a gap or drives the next beat in its place.
  task automatic send_beat(input op_t op, input in_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_entry(input int ch, input logic [7:0] v, input logic [11:0] off,
                            input logic ok);
    in_beat_t b;
    b = random_beat();
    b.entry_channel = 2'(ch);
    b.entry_value   = v;
    b.entry_offset  = off;
    b.entry_valid   = ok;
    send_beat(OP_LOAD, b);
    if (ch < MAX_CHANNELS && !loaded[ch][v]) begin
      loaded[ch][v] = 1'b1;
      loaded_count[ch]++;
    end
  endtask

  task automatic accum_pixel(input logic [7:0] a, input logic [7:0] bv, input logic [7:0] c,
                             input logic [7:0] w, input logic en);
    in_beat_t b;
    b = random_beat();
    b.chan_a_value  = a;
    b.chan_b_value  = bv;
    b.chan_c_value  = c;
    b.pixel_weight  = w;
    b.pixel_enabled = en;
    send_beat(OP_ACCUM, b);
  endtask

  task automatic read_bin(input logic [11:0] addr);
    in_beat_t b;
    b = random_beat();
    b.read_address = addr;
    send_beat(OP_READ, b);
  endtask

  // Both registers, back to back; valid is dropped only after the second beat.
  task automatic program_config(input logic [1:0] chans, input logic weights);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= chans;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_USE_WEIGHTS;
    cfg_data  <= {1'b0, weights};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every pending read, then long enough for a clear sweep to finish, since
  // accumulates and clears give no result that would show the block is idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 62; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 62; end
      default:       begin send_idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  // Mostly pixels over the uniform table, with loads that reshape it (now and then a
  // wild offset, an invalid entry or the unused fourth channel), reads aimed at the
  // populated bins, and a rare clear.
  task automatic random_item();
    in_beat_t b;
    int       r;
    int       ch;
    int       w;
    r = $urandom_range(0, 99);
    b = random_beat();
    if (r == 0 && clears_left > 0) begin
      clears_left--;
      send_beat(OP_CLEAR, b);
    end else if (r < 60) begin
      w = $urandom_range(0, 19);
      if (w == 0) b.pixel_weight = 8'd0;
      else if (w == 1) b.pixel_weight = 8'd255;
      b.pixel_enabled = ($urandom_range(0, 9) != 0);
      send_beat(OP_ACCUM, b);
    end else if (r < 78) begin
      ch = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      load_entry(ch, b.entry_value,
                 ($urandom_range(0, 4) == 0) ? b.entry_offset
                                             : uniform_offset(ch, b.entry_value),
                 $urandom_range(0, 9) != 0);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 7) b.read_address = 12'($urandom_range(0, 127));
      else if (r == 7) b.read_address = 12'(BIN_DEPTH - 1);
      send_beat(OP_READ, b);
    end
  endtask

  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_ACCUM;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHANNEL_COUNT;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, three channels with weights. The block may still be sweeping its
    // bins after reset; the handshake simply holds the first beat until it is done.
    program_config(2'd3, 1'b1);
    load_entry(0, 8'd0, 12'd0, 1'b1);
    load_entry(1, 8'd0, 12'd0, 1'b1);
    load_entry(2, 8'd0, 12'd0, 1'b1);
    accum_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    accum_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);     // zero weight leaves the bin alone
    accum_pixel(8'd0, 8'd0, 8'd0, 8'd7, 1'b0);     // masked pixel
    read_bin(12'd0);
    load_entry(0, 8'd255, 12'hFFF, 1'b1);
    load_entry(1, 8'd255, 12'd1, 1'b1);
    load_entry(2, 8'd255, 12'd0, 1'b1);
    accum_pixel(8'd255, 8'd255, 8'd255, 8'd9, 1'b1); // offset sum reaches BIN_DEPTH
    load_entry(2, 8'd128, 12'd5, 1'b0);
    accum_pixel(8'd0, 8'd0, 8'd128, 8'd3, 1'b1);   // one channel's table entry is invalid
    load_entry(3, 8'd0, 12'd100, 1'b1);            // fourth channel is ignored
    accum_pixel(8'd255, 8'd0, 8'd0, 8'd1, 1'b1);   // lands in the last bin
    accum_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    read_bin(12'(BIN_DEPTH - 1));
    read_bin(12'd0);
    send_beat(OP_CLEAR, random_beat());
    read_bin(12'd0);
    read_bin(12'(BIN_DEPTH - 1));

    // Uniform binning for a spread of values on every channel; 255 is remapped too.
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      for (int i = 0; i < 16; i++) begin
        automatic logic [7:0] v = (i == 0) ? 8'd255 : 8'($urandom_range(0, 254));
        load_entry(ch, v, uniform_offset(ch, v), 1'b1);
      end
    end

    // Random phases: every channel count, both weighting modes, each idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_config(2'(p % 4), 1'((p / 4 + p) % 2));
      set_idling(idle_mode_t'((p + 1) % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    drain();
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
